FILE: src/svu_pkg.sv
// shared types, constants and helpers for the steering vehicle update block
package svu_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ResW    = 48;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_MASS      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED = 3'd1;

  localparam logic [30:0] MASS_RST      = 31'd65536;
  localparam logic [30:0] MAX_SPEED_RST = 31'd6553600;
  localparam logic [31:0] START_X_RST   = 32'd0;
  localparam logic [31:0] START_Y_RST   = 32'd0;
  localparam logic [17:0] START_HX_RST  = 18'd65536;
  localparam logic [17:0] START_HY_RST  = 18'd0;

  // squared speed threshold, floor of 1e-5 in q32.32
  localparam logic [63:0] EPS_SQ = 64'd42949;

  // quotient widths per division kind
  localparam logic [6:0] QB_ACCEL = 7'd48;
  localparam logic [6:0] QB_TRUNC = 7'd32;
  localparam logic [6:0] QB_HEAD  = 7'd17;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } op_e;

  typedef struct packed {
    logic       start;
    op_e        op;
    logic [6:0] qbits;
  } iter_req_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < -50'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: src/svu_iter.sv
// shared iterative unit: restoring divide or integer square root, one bit a cycle
module svu_iter import svu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iter_req_t        req_i,
  input  logic [63:0]      num_i,
  input  logic [31:0]      den_i,
  output logic             done_o,
  output logic [ResW-1:0]  res_o
);

  logic            busy_q, done_q;
  logic [6:0]      cnt_q;
  op_e             op_q;
  logic [35:0]     rem_q;
  logic [63:0]     acc_q;
  logic [ResW-1:0] quo_q;
  logic [31:0]     den_q;

  logic [35:0] div_trial, sqrt_rem, sqrt_try;
  logic        div_ge, sqrt_ge;

  always_comb begin
    div_trial = {rem_q[34:0], acc_q[63]};
    div_ge    = div_trial >= {4'd0, den_q};
    sqrt_rem  = {rem_q[33:0], acc_q[63:62]};
    sqrt_try  = {2'd0, quo_q[31:0], 2'b01};
    sqrt_ge   = sqrt_rem >= sqrt_try;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
      rem_q  <= '0;
      acc_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        den_q  <= den_i;
        quo_q  <= '0;
        unique case (req_i.op)
          OP_DIV: begin
            // quotient is known to fit qbits, so the top part seeds the remainder
            rem_q <= {4'd0, 32'(num_i >> req_i.qbits)};
            acc_q <= num_i << (7'd64 - req_i.qbits);
            cnt_q <= req_i.qbits;
          end
          OP_SQRT: begin
            rem_q <= '0;
            acc_q <= num_i;
            cnt_q <= 7'd32;
          end
          default: ;
        endcase
      end else if (busy_q) begin
        unique case (op_q)
          OP_DIV: begin
            rem_q <= div_ge ? (div_trial - {4'd0, den_q}) : div_trial;
            quo_q <= {quo_q[ResW-2:0], div_ge};
            acc_q <= {acc_q[62:0], 1'b0};
          end
          OP_SQRT: begin
            rem_q <= sqrt_ge ? (sqrt_rem - sqrt_try) : sqrt_rem;
            quo_q <= {quo_q[ResW-2:0], sqrt_ge};
            acc_q <= {acc_q[61:0], 2'b00};
          end
          default: ;
        endcase
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

FILE: src/steering_vehicle_update.sv
// top level: sequencer, state registers and multiplier of the steering vehicle update
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data | in
//   in      | in_valid_i in_ready_o force_x/y          | in
//   out     | out_valid_o out_ready_i pos/heading/vel  | out
//
// each item runs two 48-bit divides for the acceleration, a square root and two
// 32-bit divides for the limit when the speed is limited, and a square root and
// two 17-bit divides for the heading when the vehicle moves, all on the one shared
// iterative unit, one quotient or root bit per cycle
// reset loads position and heading from the reset values of the start registers
// the input is not ready while an item is in work; a finished result waits in the
// output register and the next item is taken meanwhile
module steering_vehicle_update import svu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [17:0] heading_x_o,
  output logic signed [17:0] heading_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic               moved_o
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_ADIV  = 16'h0002,
    S_AWAIT = 16'h0004,
    S_SQX   = 16'h0008,
    S_SQY   = 16'h0010,
    S_SQSUM = 16'h0020,
    S_LIM   = 16'h0040,
    S_TSQW  = 16'h0080,
    S_TMUL  = 16'h0100,
    S_TDIV  = 16'h0200,
    S_TWAIT = 16'h0400,
    S_EPS   = 16'h0800,
    S_MSQW  = 16'h1000,
    S_HDIV  = 16'h2000,
    S_HWAIT = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // configuration; start registers only matter at reset, which restores them too
  logic [30:0] mass_q, max_speed_q;

  // kept vehicle state
  logic [31:0] vel_x_q, vel_y_q, pos_x_q, pos_y_q;
  logic [17:0] head_x_q, head_y_q;

  // per item working registers
  logic [31:0] fx_q, fy_q;
  logic        comp_q;      // 0 works on x, 1 on y
  logic        trunc_done_q;
  logic        moved_q;
  logic [63:0] sq_q;
  logic [31:0] len_q;
  logic [63:0] prod_q;

  // output register
  logic        out_valid_q;
  logic [31:0] o_pos_x_q, o_pos_y_q, o_vel_x_q, o_vel_y_q;
  logic [17:0] o_head_x_q, o_head_y_q;
  logic        o_moved_q;

  // shared unit
  iter_req_t       req;
  logic [63:0]     it_num;
  logic [31:0]     it_den;
  logic            it_done;
  logic [ResW-1:0] it_res;

  svu_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .num_i  (it_num),
    .den_i  (it_den),
    .done_o (it_done),
    .res_o  (it_res)
  );

  logic [31:0]        v_cur, f_cur, mass_eff, mul_a, mul_b, trunc_v;
  logic signed [49:0] q_signed, accel_sum, posx_sum, posy_sum;
  logic [17:0]        head_v;
  logic               out_load;

  assign v_cur    = comp_q ? vel_y_q : vel_x_q;
  assign f_cur    = comp_q ? fy_q : fx_q;
  assign mass_eff = (mass_q == 31'd0) ? 32'd1 : {1'b0, mass_q};

  // quotient with the sign of the current operand
  always_comb begin
    logic neg;
    neg      = (state_q == S_AWAIT) ? f_cur[31] : v_cur[31];
    q_signed = neg ? -$signed({2'b00, it_res}) : $signed({2'b00, it_res});
  end

  assign accel_sum = $signed({{18{v_cur[31]}}, v_cur}) + q_signed;
  assign posx_sum  = $signed({{18{pos_x_q[31]}}, pos_x_q})
                   + $signed({{18{vel_x_q[31]}}, vel_x_q});
  assign posy_sum  = $signed({{18{pos_y_q[31]}}, pos_y_q})
                   + $signed({{18{vel_y_q[31]}}, vel_y_q});
  assign trunc_v   = q_signed[31:0];
  assign head_v    = q_signed[17:0];
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // multiplier operands, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQX:   begin mul_a = mag32(vel_x_q); mul_b = mag32(vel_x_q); end
      S_SQY:   begin mul_a = mag32(vel_y_q); mul_b = mag32(vel_y_q); end
      S_SQSUM: begin mul_a = {1'b0, max_speed_q}; mul_b = {1'b0, max_speed_q}; end
      S_TMUL:  begin mul_a = mag32(v_cur); mul_b = {1'b0, max_speed_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // iterative unit requests
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_DIV;
    req.qbits = QB_ACCEL;
    it_num    = '0;
    it_den    = len_q;
    unique case (state_q)
      S_ADIV: begin
        req.start = 1'b1;
        it_num    = {16'd0, mag32(f_cur), 16'd0};
        it_den    = mass_eff;
      end
      S_LIM: begin
        req.start = sq_q > prod_q;
        req.op    = OP_SQRT;
        it_num    = sq_q;
      end
      S_TDIV: begin
        req.start = 1'b1;
        req.qbits = QB_TRUNC;
        it_num    = prod_q;
      end
      S_EPS: begin
        req.start = sq_q > EPS_SQ;
        req.op    = OP_SQRT;
        it_num    = sq_q;
      end
      S_HDIV: begin
        req.start = 1'b1;
        req.qbits = QB_HEAD;
        it_num    = {16'd0, mag32(v_cur), 16'd0};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ADIV;
      S_ADIV:  state_d = S_AWAIT;
      S_AWAIT: if (it_done) state_d = comp_q ? S_SQX : S_ADIV;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SQSUM;
      S_SQSUM: state_d = trunc_done_q ? S_EPS : S_LIM;
      S_LIM:   state_d = (sq_q > prod_q) ? S_TSQW : S_EPS;
      S_TSQW:  if (it_done) state_d = S_TMUL;
      S_TMUL:  state_d = S_TDIV;
      S_TDIV:  state_d = S_TWAIT;
      S_TWAIT: if (it_done) state_d = comp_q ? S_SQX : S_TMUL;
      S_EPS:   state_d = (sq_q > EPS_SQ) ? S_MSQW : S_OUT;
      S_MSQW:  if (it_done) state_d = S_HDIV;
      S_HDIV:  state_d = S_HWAIT;
      S_HWAIT: if (it_done) state_d = comp_q ? S_OUT : S_HDIV;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mass_q       <= MASS_RST;
      max_speed_q  <= MAX_SPEED_RST;
      vel_x_q      <= '0;
      vel_y_q      <= '0;
      pos_x_q      <= START_X_RST;
      pos_y_q      <= START_Y_RST;
      head_x_q     <= START_HX_RST;
      head_y_q     <= START_HY_RST;
      fx_q         <= '0;
      fy_q         <= '0;
      comp_q       <= 1'b0;
      trunc_done_q <= 1'b0;
      moved_q      <= 1'b0;
      sq_q         <= '0;
      len_q        <= '0;
      out_valid_q  <= 1'b0;
      o_pos_x_q    <= '0;
      o_pos_y_q    <= '0;
      o_vel_x_q    <= '0;
      o_vel_y_q    <= '0;
      o_head_x_q   <= '0;
      o_head_y_q   <= '0;
      o_moved_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // start registers and unknown indexes are dropped
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MASS)      mass_q      <= cfg_data_i[30:0];
        if (cfg_index_i == CFG_MAX_SPEED) max_speed_q <= cfg_data_i[30:0];
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            fx_q         <= force_x_i;
            fy_q         <= force_y_i;
            comp_q       <= 1'b0;
            trunc_done_q <= 1'b0;
            moved_q      <= 1'b0;
          end
        end
        S_AWAIT: begin
          if (it_done) begin
            if (comp_q) vel_y_q <= sat32(accel_sum);
            else        vel_x_q <= sat32(accel_sum);
            comp_q <= ~comp_q;
          end
        end
        S_SQY:   sq_q <= prod_q;
        S_SQSUM: sq_q <= sq_q + prod_q;
        S_TSQW: begin
          if (it_done) begin
            len_q  <= it_res[31:0];
            comp_q <= 1'b0;
          end
        end
        S_TWAIT: begin
          if (it_done) begin
            if (comp_q) vel_y_q <= trunc_v;
            else        vel_x_q <= trunc_v;
            comp_q       <= ~comp_q;
            trunc_done_q <= comp_q;
          end
        end
        S_MSQW: begin
          if (it_done) begin
            len_q   <= it_res[31:0];
            comp_q  <= 1'b0;
            moved_q <= 1'b1;
            pos_x_q <= sat32(posx_sum);
            pos_y_q <= sat32(posy_sum);
          end
        end
        S_HWAIT: begin
          if (it_done) begin
            if (comp_q) head_y_q <= head_v;
            else        head_x_q <= head_v;
            comp_q <= ~comp_q;
          end
        end
        default: ;
      endcase

      // output register, freed by a transfer
      if (out_load) begin
        out_valid_q <= 1'b1;
        o_pos_x_q   <= pos_x_q;
        o_pos_y_q   <= pos_y_q;
        o_vel_x_q   <= vel_x_q;
        o_vel_y_q   <= vel_y_q;
        o_head_x_q  <= head_x_q;
        o_head_y_q  <= head_y_q;
        o_moved_q   <= moved_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = o_pos_x_q;
  assign pos_y_o     = o_pos_y_q;
  assign heading_x_o = o_head_x_q;
  assign heading_y_o = o_head_y_q;
  assign vel_x_o     = o_vel_x_q;
  assign vel_y_o     = o_vel_y_q;
  assign moved_o     = o_moved_q;

endmodule

FILE: sim/tb_top.sv
// testbench for the steering vehicle update: table-driven and random force items,
// each result checked against its typed expectation or a bit-exact predictor
module tb_top import svu_pkg::*; ();

  // register indexes not named by the package
  localparam logic [CfgIdxW-1:0] CFG_START_X  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_Y  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_HX = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_START_HY = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_7 = 3'd7;

  localparam int unsigned SETTLE_CYCLES = 400;   // beyond the worst item latency
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned ITEMS_PER_PHASE = 70;
  localparam int unsigned NUM_PHASES = 10;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [17:0] heading_x;
    logic [17:0] heading_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic        moved;
  } vehicle_update_t;

  typedef struct {
    logic [31:0]     fx;
    logic [31:0]     fy;
    bit              typed;
    vehicle_update_t want;
  } force_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] force_x_i = '0;
  logic signed [31:0] force_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o;
  logic signed [17:0] heading_x_o, heading_y_o;
  logic               moved_o;

  steering_vehicle_update uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the block's registers and state
  longint unsigned mass_q, max_speed_q;
  longint          vel_x_q, vel_y_q, pos_x_q, pos_y_q, head_x_q, head_y_q;

  vehicle_update_t expected_updates[$];
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;
  bit              no_idle = 1'b0;  // stretch with both sides always busy

  function automatic longint unsigned mag64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // |a| * k / d, truncated, sign of a restored
  function automatic longint mul_div(input longint a, input longint unsigned k,
                                     input longint unsigned d);
    longint unsigned q;
    q = (mag64(a) * k) / d;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vehicle_update_t advance_vehicle(input logic [31:0] fx,
                                                      input logic [31:0] fy);
    longint unsigned m, sq, len;
    vehicle_update_t u;
    m = (mass_q == 0) ? 1 : mass_q;
    vel_x_q = clamp32(vel_x_q + mul_div(longint'(signed'(fx)), 65536, m));
    vel_y_q = clamp32(vel_y_q + mul_div(longint'(signed'(fy)), 65536, m));
    sq = mag64(vel_x_q) * mag64(vel_x_q) + mag64(vel_y_q) * mag64(vel_y_q);
    // speed limiting
    if (sq > max_speed_q * max_speed_q) begin
      len = root64(sq);
      vel_x_q = mul_div(vel_x_q, max_speed_q, len);
      vel_y_q = mul_div(vel_y_q, max_speed_q, len);
      sq = mag64(vel_x_q) * mag64(vel_x_q) + mag64(vel_y_q) * mag64(vel_y_q);
    end
    u.moved = (sq > EPS_SQ);
    if (u.moved) begin
      len = root64(sq);
      pos_x_q = clamp32(pos_x_q + vel_x_q);
      pos_y_q = clamp32(pos_y_q + vel_y_q);
      head_x_q = mul_div(vel_x_q, 65536, len);
      head_y_q = mul_div(vel_y_q, 65536, len);
    end
    u.pos_x = pos_x_q[31:0];
    u.pos_y = pos_y_q[31:0];
    u.heading_x = head_x_q[17:0];
    u.heading_y = head_y_q[17:0];
    u.vel_x = vel_x_q[31:0];
    u.vel_y = vel_y_q[31:0];
    return u;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random ready, check each transfer against the oldest expectation
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = idle_gap();
      if (g != 0) begin
        out_ready_i = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vehicle_update_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_updates.size() == 0) begin
        $error("result transfer with no expectation waiting");
        error_count++;
      end else begin
        w = expected_updates.pop_front();
        if (pos_x_o !== w.pos_x) begin
          $error("pos_x expected %h actual %h", w.pos_x, pos_x_o); error_count++;
        end
        if (pos_y_o !== w.pos_y) begin
          $error("pos_y expected %h actual %h", w.pos_y, pos_y_o); error_count++;
        end
        if (heading_x_o !== w.heading_x) begin
          $error("heading_x expected %h actual %h", w.heading_x, heading_x_o);
          error_count++;
        end
        if (heading_y_o !== w.heading_y) begin
          $error("heading_y expected %h actual %h", w.heading_y, heading_y_o);
          error_count++;
        end
        if (vel_x_o !== w.vel_x) begin
          $error("vel_x expected %h actual %h", w.vel_x, vel_x_o); error_count++;
        end
        if (vel_y_o !== w.vel_y) begin
          $error("vel_y expected %h actual %h", w.vel_y, vel_y_o); error_count++;
        end
        if (moved_o !== w.moved) begin
          $error("moved expected %b actual %b", w.moved, moved_o); error_count++;
        end
      end
    end
  end

  // one register write transfer; only called while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MASS:      mass_q = val[30:0];
      CFG_MAX_SPEED: max_speed_q = val[30:0];
      default: ;  // start registers only act at reset, other indexes are ignored
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one force transfer; expectation queued at the accepting edge
  task automatic send_force(input logic [31:0] fx, input logic [31:0] fy,
                            input bit typed, input vehicle_update_t want);
    vehicle_update_t p;
    int unsigned g;
    g = idle_gap();
    if (g != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    force_x_i = fx;
    force_y_i = fy;
    do @(posedge clk_i); while (!in_ready_o);
    p = advance_vehicle(fx, fy);
    expected_updates.push_back(typed ? want : p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_force(input longint vel, input longint unsigned m);
    int unsigned k;
    longint c;
    k = $urandom_range(99);
    if (k < 40) return 32'($signed($urandom_range(2097152)) - 1048576);
    if (k < 55) return $urandom;
    if (k < 70) begin
      // pull the velocity back near zero so that the object stops
      c = -((vel * longint'(m == 0 ? 1 : m)) / 65536);
      return 32'(clamp32(c + $signed($urandom_range(4)) - 2));
    end
    if (k < 85) return 32'($signed($urandom_range(512)) - 256);
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  force_row_t rows[$];
  logic [30:0] phase_mass[NUM_PHASES];
  logic [30:0] phase_speed[NUM_PHASES];

  initial begin
    force_row_t r;
    vehicle_update_t none;
    none = '0;
    mass_q = MASS_RST;
    max_speed_q = MAX_SPEED_RST;
    vel_x_q = 0; vel_y_q = 0;
    pos_x_q = signed'(START_X_RST);
    pos_y_q = signed'(START_Y_RST);
    head_x_q = longint'(signed'(START_HX_RST));
    head_y_q = longint'(signed'(START_HY_RST));

    // directed table: typed rows right after reset, then predictor-checked extremes
    r.typed = 1'b1;
    r.fx = 32'd0; r.fy = 32'd0;  // no movement from rest
    r.want = '{32'd0, 32'd0, 18'd65536, 18'd0, 32'd0, 32'd0, 1'b0};
    rows.push_back(r);
    r.fx = 32'd65536;  // one unit along x
    r.want = '{32'd65536, 32'd0, 18'd65536, 18'd0, 32'd65536, 32'd0, 1'b1};
    rows.push_back(r);
    r.fx = -32'sd65536;  // back to rest, position and heading kept
    r.want = '{32'd65536, 32'd0, 18'd65536, 18'd0, 32'd0, 32'd0, 1'b0};
    rows.push_back(r);
    r.typed = 1'b0;
    r.want = none;
    r.fx = 32'h7fff_ffff; r.fy = 32'h8000_0000; rows.push_back(r);
    r.fx = 32'h8000_0000; r.fy = 32'h7fff_ffff; rows.push_back(r);
    r.fx = 32'h8000_0000; r.fy = 32'h8000_0000; rows.push_back(r);
    r.fx = 32'h0;         r.fy = 32'h7fff_ffff; rows.push_back(r);
    r.fx = 32'hffff_ffff; r.fy = 32'h0;         rows.push_back(r);
    r.fx = 32'h0001_0000; r.fy = 32'hffff_0000; rows.push_back(r);
    r.fx = 32'h0;         r.fy = 32'h0;         rows.push_back(r);
    r.fx = 32'h0000_0001; r.fy = 32'h0000_0001; rows.push_back(r);
    r.fx = 32'h0640_0000; r.fy = 32'h0;         rows.push_back(r);

    // phases of mass and speed limit: zero mass, extremes and middle values
    phase_mass  = '{31'd65536, 31'd0, 31'h7fff_ffff, 31'd65536, 31'd1,
                    31'd1048576, 31'd65536, 31'd32768, 31'd0, 31'd65536};
    phase_speed = '{31'd6553600, 31'd6553600, 31'h7fff_ffff, 31'd0, 31'd196608,
                    31'h7fff_ffff, 31'd1, 31'd65536, 31'h7fff_ffff, 31'd6553600};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_force(rows[i].fx, rows[i].fy, rows[i].typed, rows[i].want);
    // the sender holds off here until every result has come
    drain();

    // start registers act only at reset and unused indexes are dropped
    write_reg(CFG_START_X, $urandom);
    write_reg(CFG_START_Y, 32'h8000_0000);
    write_reg(CFG_START_HX, 32'h0002_0000);
    write_reg(CFG_START_HY, 32'h0003_ffff);
    write_reg(CFG_UNUSED_6, 32'h0000_0001);
    write_reg(CFG_UNUSED_7, 32'hffff_ffff);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_MASS, {1'($urandom_range(1)), phase_mass[p]});
      write_reg(CFG_MAX_SPEED, {1'($urandom_range(1)), phase_speed[p]});
      no_idle = (p % 4 == 2);
      repeat (ITEMS_PER_PHASE)
        send_force(random_force(vel_x_q, mass_q), random_force(vel_y_q, mass_q),
                   1'b0, none);
      no_idle = 1'b0;
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
